// ----- rtl/core/hxi_pkg.sv -----
package hxi_pkg;

  localparam int COORD_W = 16;
  localparam int INDEX_W = 32;
  localparam int ORDER_W = 5;

  localparam int                 DEFAULT_MAX_ORDER = 16;
  localparam logic [ORDER_W-1:0] ORDER_RESET       = 5'd16;

  // Quadrant codes: {bit of j, bit of i xor bit of j}
  localparam logic [1:0] Q_SWAP  = 2'd0;
  localparam logic [1:0] Q_RIGHT = 2'd1;
  localparam logic [1:0] Q_UPPER = 2'd2;
  localparam logic [1:0] Q_FLIP  = 2'd3;

  // One item in flight through the level chain
  typedef struct packed {
    logic [COORD_W-1:0] i;
    logic [COORD_W-1:0] j;
    logic [INDEX_W-1:0] idx;
    logic [ORDER_W-1:0] order;
    logic               oor;
  } item_t;

endpackage

// ----- rtl/core/hxi_ifs.sv -----
interface hxi_coord_if;
  logic                        valid;
  logic                        ready;
  logic [hxi_pkg::COORD_W-1:0] x_coord;
  logic [hxi_pkg::COORD_W-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface hxi_index_if;
  logic                        valid;
  logic                        ready;
  logic [hxi_pkg::INDEX_W-1:0] curve_index;
  logic                        out_of_range;

  modport source (output valid, output curve_index, output out_of_range, input ready);
  modport sink (input valid, input curve_index, input out_of_range, output ready);
endinterface

interface hxi_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [hxi_pkg::ORDER_W-1:0] grid_order;

  modport source (output valid, output grid_order, input ready);
  modport sink (input valid, input grid_order, output ready);
endinterface

// ----- rtl/core/hxi_entry.sv -----
module hxi_entry (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [hxi_pkg::ORDER_W-1:0] order,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [hxi_pkg::COORD_W-1:0] x_coord,
  input  logic [hxi_pkg::COORD_W-1:0] y_coord,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output hxi_pkg::item_t              dn_item
);

  hxi_pkg::item_t item_next;

  // Any coordinate bit at or above the order puts the point off the grid
  always_comb begin
    item_next.i     = x_coord;
    item_next.j     = y_coord;
    item_next.idx   = '0;
    item_next.order = order;
    item_next.oor   = ((x_coord >> order) != '0) || ((y_coord >> order) != '0);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= item_next;
    end
  end

endmodule

// ----- rtl/core/hxi_level.sv -----
module hxi_level #(
  parameter int LEVEL = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  hxi_pkg::item_t up_item,
  output logic           dn_valid,
  input  logic           dn_ready,
  output hxi_pkg::item_t dn_item
);

  // Half side of this level is 2^BIT_POS
  localparam int BIT_POS   = LEVEL - 1;
  localparam bit HAS_BIT   = BIT_POS < hxi_pkg::COORD_W;
  localparam int BIT_SEL   = HAS_BIT ? BIT_POS : 0;
  localparam bit HAS_IDX   = 2 * BIT_POS <= hxi_pkg::INDEX_W - 2;
  localparam int IDX_SHIFT = HAS_IDX ? 2 * BIT_POS : 0;
  localparam logic [hxi_pkg::COORD_W-1:0] LOW_MASK =
    HAS_BIT ? hxi_pkg::COORD_W'((1 << BIT_POS) - 1) : '1;

  logic           bi;
  logic           bj;
  logic [1:0]     q;
  logic           active;
  hxi_pkg::item_t item_next;

  assign bi     = HAS_BIT && up_item.i[BIT_SEL];
  assign bj     = HAS_BIT && up_item.j[BIT_SEL];
  assign q      = {bj, bi ^ bj};
  assign active = (up_item.order >= hxi_pkg::ORDER_W'(LEVEL)) && !up_item.oor;

  always_comb begin
    item_next = up_item;
    if (active) begin
      case (q) inside
        hxi_pkg::Q_SWAP: begin
          item_next.i = up_item.j & LOW_MASK;
          item_next.j = up_item.i & LOW_MASK;
        end
        hxi_pkg::Q_RIGHT, hxi_pkg::Q_UPPER: begin
          item_next.i = up_item.i & LOW_MASK;
          item_next.j = up_item.j & LOW_MASK;
        end
        default: begin
          // reflect across the anti-diagonal of the quadrant
          item_next.i = ~up_item.j & LOW_MASK;
          item_next.j = ~up_item.i & LOW_MASK;
        end
      endcase
      if (HAS_IDX) begin
        item_next.idx = up_item.idx | (hxi_pkg::INDEX_W'(q) << IDX_SHIFT);
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= item_next;
    end
  end

endmodule

// ----- rtl/core/hilbert_xy_to_index.sv -----
// Hilbert curve index of a grid point: takes one (x_coord, y_coord) transfer per clock
// while the result side is ready and returns curve_index with out_of_range, in order,
// through one register stage per curve level plus one entry stage for the range check;
// stalls on the result side hold every stage.
// grid_order (reset 16) saturates at MAX_ORDER; write it only while no item is in flight.
// A point with a coordinate at or above 2^grid_order gives out_of_range = 1 and index 0.
module hilbert_xy_to_index #(
  parameter int MAX_ORDER = hxi_pkg::DEFAULT_MAX_ORDER
) (
  input  logic        clk,
  input  logic        rst,
  hxi_cfg_if.sink     cfg,
  hxi_coord_if.sink   coords,
  hxi_index_if.source result
);

  logic [hxi_pkg::ORDER_W-1:0] grid_order;
  logic [hxi_pkg::ORDER_W-1:0] eff_order;

  logic           stage_valid [0:MAX_ORDER];
  logic           stage_ready [0:MAX_ORDER];
  hxi_pkg::item_t stage_item  [0:MAX_ORDER];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_order <= hxi_pkg::ORDER_RESET;
    end else if (cfg.valid) begin
      grid_order <= cfg.grid_order;
    end
  end

  assign eff_order = (grid_order > hxi_pkg::ORDER_W'(MAX_ORDER)) ?
                     hxi_pkg::ORDER_W'(MAX_ORDER) : grid_order;

  hxi_entry u_entry (
    .clk      (clk),
    .rst      (rst),
    .order    (eff_order),
    .up_valid (coords.valid),
    .up_ready (coords.ready),
    .x_coord  (coords.x_coord),
    .y_coord  (coords.y_coord),
    .dn_valid (stage_valid[0]),
    .dn_ready (stage_ready[0]),
    .dn_item  (stage_item[0])
  );

  // Walk from the top level down: stage n handles level MAX_ORDER - n + 1
  for (genvar n = 1; n <= MAX_ORDER; n++) begin : g_level
    hxi_level #(
      .LEVEL (MAX_ORDER - n + 1)
    ) u_level (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stage_valid[n-1]),
      .up_ready (stage_ready[n-1]),
      .up_item  (stage_item[n-1]),
      .dn_valid (stage_valid[n]),
      .dn_ready (stage_ready[n]),
      .dn_item  (stage_item[n])
    );
  end

  assign result.valid          = stage_valid[MAX_ORDER];
  assign stage_ready[MAX_ORDER] = result.ready;
  assign result.curve_index    = stage_item[MAX_ORDER].idx;
  assign result.out_of_range   = stage_item[MAX_ORDER].oor;

endmodule
